FILE: hw/rtl/ordered_id_pool_defines.svh
// Assertion macros shared by the ordered ID pool RTL.
// No dependencies; included by the controller and datapath files.
`ifndef ORDERED_ID_POOL_DEFINES_SVH
`define ORDERED_ID_POOL_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define OIP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered_id_pool: check failed");

// Check a condition in the cycle after its trigger
`define OIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered_id_pool: check failed");

`endif

FILE: hw/rtl/oip_pkg.sv
// Shared constants, codes and control structs of the ordered ID pool.
// No dependencies; used by every module of the block except oip_ram.
`default_nettype none

package oip_pkg;

    localparam int POOL_SIZE  = 1024;
    localparam int ID_W       = 16;
    localparam int SPAN_W     = ID_W + 1;
    localparam int SLOT_W     = $clog2(POOL_SIZE);
    localparam int CNT_W      = $clog2(POOL_SIZE + 1);
    localparam int OUT_CNT_W  = 11;
    localparam int ACT_W      = 2;
    localparam int CFG_W      = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL_BIT = 2;

    // Range after reset and the pool size it gives
    localparam int RESET_FIRST = 0;
    localparam int RESET_LAST  = 1023;
    localparam int RESET_SPAN  = RESET_LAST - RESET_FIRST + 1;
    localparam int RESET_N     = (RESET_SPAN > POOL_SIZE) ? POOL_SIZE : RESET_SPAN;

    typedef enum logic [ACT_W-1:0] {
        ACT_INIT       = 2'd0,
        ACT_TAKE_FRONT = 2'd1,
        ACT_TAKE_ID    = 2'd2,
        ACT_GIVE_BACK  = 2'd3
    } action_t;

    typedef enum logic {
        REG_RANGE_FIRST = 1'b0,
        REG_RANGE_LAST  = 1'b1
    } reg_idx_t;

    // Read address source for the link and membership RAMs
    typedef enum logic [1:0] {
        RD_SLOT  = 2'd0,
        RD_FRONT = 2'd1,
        RD_CHAIN = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        logic    init_start;
        logic    sweep_step;
        logic    take_start;
        logic    take_step;
        logic    named_exec;
        logic    out_load;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic take_ok;
        logic sweep_last;
        logic step_last;
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oip_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module oip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/oip_ctrl.sv
// Controller state machine of the ordered ID pool: sequences sweeps, steps and results.
// Depends on oip_pkg and ordered_id_pool_defines.svh.
`default_nettype none
`include "ordered_id_pool_defines.svh"

module oip_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [oip_pkg::ACT_W-1:0]   s_action,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    input  wire oip_pkg::status_t            status,
    output oip_pkg::cmd_t                    cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_INIT   = 6'b000100,
        ST_EXEC   = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             m_valid_reg;
    oip_pkg::action_t act_in;

    assign act_in  = oip_pkg::action_t'(s_action);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Decode state into datapath commands and the next state
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = oip_pkg::RD_SLOT;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (act_in == oip_pkg::ACT_TAKE_FRONT) begin
                    cmd.rd_sel = oip_pkg::RD_FRONT;
                end
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    case (act_in)
                        oip_pkg::ACT_INIT: begin
                            cmd.init_start = 1'b1;
                            state_next     = ST_INIT;
                        end
                        oip_pkg::ACT_TAKE_FRONT: begin
                            if (status.take_ok) begin
                                cmd.take_start = 1'b1;
                                state_next     = ST_STEP;
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end
                        default: begin
                            state_next = ST_EXEC;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_EXEC: begin
                cmd.named_exec = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_STEP: begin
                cmd.take_step = 1'b1;
                cmd.rd_sel    = oip_pkg::RD_CHAIN;
                if (status.step_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state and hold the result item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `OIP_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE)
    `OIP_ASSERT_NOW(a_load_into_free_slot, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)

endmodule

`default_nettype wire

FILE: hw/rtl/oip_dp.sv
// Datapath of the ordered ID pool: link RAMs, membership RAM, pointers and result item.
// Depends on oip_pkg, oip_ram and ordered_id_pool_defines.svh.
`default_nettype none
`include "ordered_id_pool_defines.svh"

module oip_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire oip_pkg::cmd_t                 cmd,
    output oip_pkg::status_t                   status,
    input  wire logic [oip_pkg::ACT_W-1:0]     s_action,
    input  wire logic [oip_pkg::ID_W-1:0]      s_operand,
    input  wire logic [oip_pkg::ID_W-1:0]      range_first,
    input  wire logic [oip_pkg::ID_W-1:0]      range_last,
    output logic      [oip_pkg::ID_W-1:0]      m_front_id,
    output logic      [oip_pkg::OUT_CNT_W-1:0] m_pool_count,
    output logic                               m_pool_empty,
    output logic                               m_applied
);

    localparam int SLOT_W = oip_pkg::SLOT_W;
    localparam int CNT_W  = oip_pkg::CNT_W;
    localparam int SPAN_W = oip_pkg::SPAN_W;
    localparam int ID_W   = oip_pkg::ID_W;

    // Control state
    logic [SLOT_W-1:0] front_reg;
    logic [SLOT_W-1:0] back_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [SLOT_W-1:0] cnt_reg;

    // Item context
    oip_pkg::action_t  act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              in_range_reg;
    logic              applied_reg;
    logic [CNT_W-1:0]  rem_reg;

    // Result item
    logic [ID_W-1:0]              front_id_reg;
    logic [oip_pkg::OUT_CNT_W-1:0] count_reg;
    logic                         empty_reg;
    logic                         applied_out_reg;

    logic [SPAN_W-1:0] span;
    logic [CNT_W-1:0]  size;
    logic [ID_W-1:0]   diff;
    logic              in_range_in;
    logic [SLOT_W-1:0] slot_in;
    logic [SLOT_W-1:0] cnt_inc;
    logic [SLOT_W-1:0] cnt_dec;

    logic [SLOT_W-1:0] raddr;
    logic [SLOT_W-1:0] nx_rdata;
    logic [SLOT_W-1:0] pv_rdata;
    logic              ip_rdata;
    logic              nx_we, pv_we, ip_we;
    logic [SLOT_W-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, ip_waddr;
    logic              ip_wdata;

    logic remove_ok, append_ok, do_rm, do_ap, middle;

    // Range size, clamped to the pool; an inverted range gives size one
    assign span = SPAN_W'(range_last) - SPAN_W'(range_first) + SPAN_W'(1);
    always_comb begin
        if (range_last < range_first) begin
            size = CNT_W'(1);
        end else if (span > SPAN_W'(oip_pkg::POOL_SIZE)) begin
            size = CNT_W'(oip_pkg::POOL_SIZE);
        end else begin
            size = CNT_W'(span);
        end
    end

    // Slot of the incoming ID
    assign diff        = s_operand - range_first;
    assign in_range_in = (s_operand >= range_first) && (SPAN_W'(diff) < SPAN_W'(size));
    assign slot_in     = diff[SLOT_W-1:0];

    assign cnt_inc = (cnt_reg == SLOT_W'(oip_pkg::POOL_SIZE - 1)) ? '0 : cnt_reg + SLOT_W'(1);
    assign cnt_dec = (cnt_reg == '0) ? SLOT_W'(oip_pkg::POOL_SIZE - 1) : cnt_reg - SLOT_W'(1);

    assign status.take_ok    = (s_operand != '0) && (SPAN_W'(s_operand) < SPAN_W'(held_reg));
    assign status.sweep_last = (cnt_reg == SLOT_W'(oip_pkg::POOL_SIZE - 1));
    assign status.step_last  = (rem_reg == CNT_W'(1));

    // Select the read address
    always_comb begin
        case (cmd.rd_sel)
            oip_pkg::RD_FRONT: raddr = front_reg;
            oip_pkg::RD_CHAIN: raddr = nx_rdata;
            default:           raddr = slot_in;
        endcase
    end

    // Named take and give back decisions
    assign remove_ok = (act_reg == oip_pkg::ACT_TAKE_ID) && in_range_reg && ip_rdata
                       && (held_reg != '0);
    assign append_ok = (act_reg == oip_pkg::ACT_GIVE_BACK) && in_range_reg && !ip_rdata
                       && (held_reg != CNT_W'(oip_pkg::POOL_SIZE));
    assign do_rm  = cmd.named_exec && remove_ok;
    assign do_ap  = cmd.named_exec && append_ok;
    assign middle = (held_reg > CNT_W'(1)) && (slot_reg != front_reg) && (slot_reg != back_reg);

    // Drive the RAM write ports
    always_comb begin
        nx_we = 1'b0; nx_waddr = cnt_reg; nx_wdata = cnt_inc;
        pv_we = 1'b0; pv_waddr = cnt_reg; pv_wdata = cnt_dec;
        ip_we = 1'b0; ip_waddr = cnt_reg; ip_wdata = (CNT_W'(cnt_reg) < n_reg);
        if (cmd.sweep_step) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            ip_we = 1'b1;
        end else if (cmd.take_step) begin
            ip_we    = 1'b1;
            ip_waddr = front_reg;
            ip_wdata = 1'b0;
        end else if (do_rm) begin
            ip_we    = 1'b1;
            ip_waddr = slot_reg;
            ip_wdata = 1'b0;
            if (middle) begin
                nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
                pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
            end
        end else if (do_ap) begin
            ip_we    = 1'b1;
            ip_waddr = slot_reg;
            ip_wdata = 1'b1;
            if (held_reg != '0) begin
                nx_we = 1'b1; nx_waddr = back_reg; nx_wdata = slot_reg;
                pv_we = 1'b1; pv_waddr = slot_reg; pv_wdata = back_reg;
            end
        end
    end

    oip_ram #(.WIDTH(SLOT_W), .DEPTH(oip_pkg::POOL_SIZE)) u_next_ram (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(raddr), .rdata(nx_rdata)
    );

    oip_ram #(.WIDTH(SLOT_W), .DEPTH(oip_pkg::POOL_SIZE)) u_prev_ram (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(raddr), .rdata(pv_rdata)
    );

    oip_ram #(.WIDTH(1), .DEPTH(oip_pkg::POOL_SIZE)) u_member_ram (
        .aclk(aclk), .we(ip_we), .waddr(ip_waddr), .wdata(ip_wdata),
        .raddr(raddr), .rdata(ip_rdata)
    );

    // Update pointers, count and sweep position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= SLOT_W'(oip_pkg::RESET_N - 1);
            held_reg  <= CNT_W'(oip_pkg::RESET_N);
            n_reg     <= CNT_W'(oip_pkg::RESET_N);
            cnt_reg   <= '0;
        end else begin
            if (cmd.init_start) begin
                n_reg     <= size;
                front_reg <= '0;
                back_reg  <= SLOT_W'(size - CNT_W'(1));
                held_reg  <= size;
                cnt_reg   <= '0;
            end
            if (cmd.sweep_step) begin
                cnt_reg <= cnt_inc;
            end
            if (cmd.take_step) begin
                front_reg <= nx_rdata;
                held_reg  <= held_reg - CNT_W'(1);
            end
            if (do_rm) begin
                held_reg <= held_reg - CNT_W'(1);
                if (held_reg <= CNT_W'(1)) begin
                    front_reg <= '0;
                    back_reg  <= '0;
                end else if (slot_reg == front_reg) begin
                    front_reg <= nx_rdata;
                end else if (slot_reg == back_reg) begin
                    back_reg <= pv_rdata;
                end
            end
            if (do_ap) begin
                held_reg <= held_reg + CNT_W'(1);
                back_reg <= slot_reg;
                if (held_reg == '0) begin
                    front_reg <= slot_reg;
                end
            end
        end
    end

    // Hold item context and the result item
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg      <= oip_pkg::action_t'(s_action);
            slot_reg     <= slot_in;
            in_range_reg <= in_range_in;
            // Init always applies, and so does an accepted take-front count
            applied_reg  <= cmd.init_start || cmd.take_start;
        end
        if (cmd.take_start) begin
            rem_reg <= CNT_W'(s_operand);
        end
        if (cmd.take_step) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
        if (cmd.named_exec) begin
            applied_reg <= remove_ok || append_ok;
        end
        if (cmd.out_load) begin
            front_id_reg    <= (held_reg == '0) ? '0 : range_first + ID_W'(front_reg);
            count_reg       <= oip_pkg::OUT_CNT_W'(held_reg);
            empty_reg       <= (held_reg == '0);
            applied_out_reg <= applied_reg;
        end
    end

    assign m_front_id   = front_id_reg;
    assign m_pool_count = count_reg;
    assign m_pool_empty = empty_reg;
    assign m_applied    = applied_out_reg;

    `OIP_ASSERT_NOW(a_held_bounded, aclk, aresetn, 1'b1, held_reg <= CNT_W'(oip_pkg::POOL_SIZE))
    `OIP_ASSERT_NOW(a_step_keeps_one, aclk, aresetn, cmd.take_step, held_reg >= CNT_W'(2))

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_id_pool.sv
// Ordered ID pool: top level with APB range registers, controller and datapath.
// init sweeps one RAM row per cycle; take-front of n IDs does one chain hop per cycle
// through the next-link RAM; named take and give back run through the execute state.
// Result appears in an output register; one item is worked at a time.
// Reset (synchronous, aresetn low) runs a fill pass over the RAMs with range
// 0..1023; no item is accepted until it ends. Range registers are read and written via APB.
`default_nettype none

module ordered_id_pool (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [oip_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [oip_pkg::CFG_W-1:0]     pwdata,
    output logic      [oip_pkg::CFG_W-1:0]     prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [oip_pkg::ACT_W-1:0]     s_action,
    input  wire logic [oip_pkg::ID_W-1:0]      s_operand,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [oip_pkg::ID_W-1:0]      m_front_id,
    output logic      [oip_pkg::OUT_CNT_W-1:0] m_pool_count,
    output logic                               m_pool_empty,
    output logic                               m_applied
);

    logic [oip_pkg::ID_W-1:0] range_first_reg;
    logic [oip_pkg::ID_W-1:0] range_last_reg;
    oip_pkg::reg_idx_t        reg_idx;
    oip_pkg::cmd_t            cmd;
    oip_pkg::status_t         status;

    assign pready  = 1'b1;
    assign reg_idx = oip_pkg::reg_idx_t'(paddr[oip_pkg::REG_SEL_BIT]);

    // Write range registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_first_reg <= oip_pkg::ID_W'(oip_pkg::RESET_FIRST);
            range_last_reg  <= oip_pkg::ID_W'(oip_pkg::RESET_LAST);
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                oip_pkg::REG_RANGE_FIRST: range_first_reg <= pwdata[oip_pkg::ID_W-1:0];
                oip_pkg::REG_RANGE_LAST:  range_last_reg  <= pwdata[oip_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register contents on read
    always_comb begin
        case (reg_idx)
            oip_pkg::REG_RANGE_FIRST: prdata = oip_pkg::CFG_W'(range_first_reg);
            oip_pkg::REG_RANGE_LAST:  prdata = oip_pkg::CFG_W'(range_last_reg);
            default:                  prdata = '0;
        endcase
    end

    oip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    oip_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_action    (s_action),
        .s_operand   (s_operand),
        .range_first (range_first_reg),
        .range_last  (range_last_reg),
        .m_front_id  (m_front_id),
        .m_pool_count(m_pool_count),
        .m_pool_empty(m_pool_empty),
        .m_applied   (m_applied)
    );

endmodule

`default_nettype wire

FILE: test/ordered_id_pool_tb.sv
// Testbench for the ordered ID pool: APB range set-up, directed table, then random items.
// Results are checked per field against table rows if fixed, else a behavioural model.
// Depends on oip_pkg and the ordered_id_pool RTL.
`default_nettype none

module ordered_id_pool_tb;

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [oip_pkg::PADDR_W-1:0]     paddr;
    logic [oip_pkg::CFG_W-1:0]       pwdata;
    logic [oip_pkg::CFG_W-1:0]       prdata;
    logic                            pready;
    logic                            s_valid;
    logic                            s_ready;
    logic [oip_pkg::ACT_W-1:0]       s_action;
    logic [oip_pkg::ID_W-1:0]        s_operand;
    logic                            m_valid;
    logic                            m_ready;
    logic [oip_pkg::ID_W-1:0]        m_front_id;
    logic [oip_pkg::OUT_CNT_W-1:0]   m_pool_count;
    logic                            m_pool_empty;
    logic                            m_applied;

    typedef struct packed {
        logic [oip_pkg::ID_W-1:0]      front_id;
        logic [oip_pkg::OUT_CNT_W-1:0] pool_count;
        logic                          pool_empty;
        logic                          applied;
    } pool_status_t;

    typedef struct {
        oip_pkg::action_t         act;
        logic [oip_pkg::ID_W-1:0] operand;
        logic                     fixed;
        pool_status_t             status;
    } stim_row_t;

    ordered_id_pool dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_operand(s_operand),
        .m_valid(m_valid), .m_ready(m_ready), .m_front_id(m_front_id),
        .m_pool_count(m_pool_count), .m_pool_empty(m_pool_empty), .m_applied(m_applied)
    );

    // Model state of the pool
    int unsigned  id_lo, id_hi;
    int unsigned  fwd_link [oip_pkg::POOL_SIZE];
    int unsigned  back_link [oip_pkg::POOL_SIZE];
    bit           held [oip_pkg::POOL_SIZE];
    int unsigned  head_slot, tail_slot, num_held;

    pool_status_t status_q[$];
    bit           failed;
    bit           hold_off;
    bit           hold_req;
    int           stall_mode;

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned span_of();
        int unsigned n;
        if (id_hi < id_lo) return 1;
        n = id_hi - id_lo + 1;
        return (n > oip_pkg::POOL_SIZE) ? oip_pkg::POOL_SIZE : n;
    endfunction

    function automatic void fill_pool();
        int unsigned n;
        n = span_of();
        for (int unsigned i = 0; i < oip_pkg::POOL_SIZE; i++) begin
            held[i] = (i < n);
            fwd_link[i] = (i + 1) % oip_pkg::POOL_SIZE;
            back_link[i] = (i + oip_pkg::POOL_SIZE - 1) % oip_pkg::POOL_SIZE;
        end
        head_slot = 0;
        tail_slot = n - 1;
        num_held = n;
    endfunction

    function automatic void drop_slot(int unsigned s);
        int unsigned p, q;
        p = back_link[s];
        q = fwd_link[s];
        if (num_held <= 1) begin
            head_slot = 0;
            tail_slot = 0;
        end else if (s == head_slot) begin
            head_slot = q;
        end else if (s == tail_slot) begin
            tail_slot = p;
        end else begin
            fwd_link[p] = q;
            back_link[q] = p;
        end
        held[s] = 0;
        num_held--;
    endfunction

    function automatic void append_slot_m(int unsigned s);
        if (num_held == 0) begin
            head_slot = s;
        end else begin
            fwd_link[tail_slot] = s;
            back_link[s] = tail_slot;
        end
        tail_slot = s;
        held[s] = 1;
        num_held++;
    endfunction

    // Apply one request to the model and return the status it reports
    function automatic pool_status_t pool_apply(oip_pkg::action_t act,
                                                logic [oip_pkg::ID_W-1:0] operand);
        pool_status_t r;
        int unsigned op, slot;
        bit ok, in_rng;
        op = operand;
        ok = 0;
        in_rng = (op >= id_lo) && (op - id_lo < span_of());
        slot = (op - id_lo) % oip_pkg::POOL_SIZE;
        case (act)
            oip_pkg::ACT_INIT: begin
                fill_pool();
                ok = 1;
            end
            oip_pkg::ACT_TAKE_FRONT: begin
                if (op < num_held && op != 0) begin
                    for (int unsigned k = 0; k < op; k++) drop_slot(head_slot);
                    ok = 1;
                end
            end
            oip_pkg::ACT_TAKE_ID: begin
                if (in_rng && held[slot] && num_held != 0) begin
                    drop_slot(slot);
                    ok = 1;
                end
            end
            default: begin
                if (in_rng && !held[slot] && num_held < oip_pkg::POOL_SIZE) begin
                    append_slot_m(slot);
                    ok = 1;
                end
            end
        endcase
        r.front_id   = (num_held == 0) ? '0 : oip_pkg::ID_W'(id_lo + head_slot);
        r.pool_count = oip_pkg::OUT_CNT_W'(num_held);
        r.pool_empty = (num_held == 0);
        r.applied    = ok;
        return r;
    endfunction

    task automatic apb_write(oip_pkg::reg_idx_t idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= oip_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= oip_pkg::CFG_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == oip_pkg::REG_RANGE_FIRST) id_lo = value;
        else id_hi = value;
        // Go idle, then read the register back
        @(posedge aclk);
        if (prdata !== oip_pkg::CFG_W'(value)) begin
            $error("prdata expected %0d actual %0d", value, prdata);
            failed = 1'b1;
        end
    endtask

    task automatic set_range(logic [15:0] lo, logic [15:0] hi);
        apb_write(oip_pkg::REG_RANGE_FIRST, lo);
        apb_write(oip_pkg::REG_RANGE_LAST, hi);
    endtask

    // Offer one item and hold it until accepted; expectation is queued at acceptance
    task automatic send_item(oip_pkg::action_t act, logic [oip_pkg::ID_W-1:0] operand,
                             bit fixed, pool_status_t want);
        pool_status_t p;
        s_valid   <= 1'b1;
        s_action  <= act;
        s_operand <= operand;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = pool_apply(act, operand);
        if (fixed && p != want)
            $error("table row disagrees with model: act %0d op %0d", act, operand);
        status_q.push_back(fixed ? want : p);
    endtask

    task automatic idle_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (oip_pkg::POOL_SIZE + 20) @(posedge aclk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                $error("result with no expectation waiting");
                failed = 1'b1;
            end else begin
                pool_status_t e;
                e = status_q.pop_front();
                if (m_front_id !== e.front_id) begin
                    $error("front_id expected %0d actual %0d", e.front_id, m_front_id);
                    failed = 1'b1;
                end
                if (m_pool_count !== e.pool_count) begin
                    $error("pool_count expected %0d actual %0d", e.pool_count, m_pool_count);
                    failed = 1'b1;
                end
                if (m_pool_empty !== e.pool_empty) begin
                    $error("pool_empty expected %0d actual %0d", e.pool_empty, m_pool_empty);
                    failed = 1'b1;
                end
                if (m_applied !== e.applied) begin
                    $error("applied expected %0d actual %0d", e.applied, m_applied);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Hold the receiver off for a long stretch while items keep coming
    initial begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Random request, mostly valid IDs and small counts
    task automatic random_item();
        oip_pkg::action_t act;
        logic [oip_pkg::ID_W-1:0] op;
        int unsigned n, r;
        n = span_of();
        r = $urandom_range(0, 99);
        if (r < 2) act = oip_pkg::ACT_INIT;
        else if (r < 30) act = oip_pkg::ACT_TAKE_FRONT;
        else if (r < 65) act = oip_pkg::ACT_TAKE_ID;
        else act = oip_pkg::ACT_GIVE_BACK;
        case ($urandom_range(0, 9))
            0: op = oip_pkg::ID_W'($urandom);
            1: op = oip_pkg::ID_W'(num_held);
            default: op = (act == oip_pkg::ACT_TAKE_FRONT)
                          ? oip_pkg::ID_W'($urandom_range(0, 6))
                          : oip_pkg::ID_W'(id_lo + $urandom_range(0, n - 1));
        endcase
        send_item(act, op, 1'b0, '0);
        if ($urandom_range(0, 3) == 0) idle_gap();
    endtask

    stim_row_t plan[$];

    initial begin
        stall_mode = 0;
        hold_req   = 1'b0;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_action   = oip_pkg::ACT_INIT;
        s_operand  = '0;
        id_lo      = oip_pkg::RESET_FIRST;
        id_hi      = oip_pkg::RESET_LAST;
        fill_pool();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: fixed rows carry {front, count, empty, applied}
        plan = '{
            '{oip_pkg::ACT_TAKE_FRONT, 16'd0,    1'b1, '{16'd0,   11'd1024, 1'b0, 1'b0}},
            '{oip_pkg::ACT_TAKE_FRONT, 16'd1024, 1'b1, '{16'd0,   11'd1024, 1'b0, 1'b0}},
            '{oip_pkg::ACT_TAKE_FRONT, 16'hFFFF, 1'b1, '{16'd0,   11'd1024, 1'b0, 1'b0}},
            '{oip_pkg::ACT_GIVE_BACK,  16'd5,    1'b1, '{16'd0,   11'd1024, 1'b0, 1'b0}},
            '{oip_pkg::ACT_TAKE_ID,    16'hFFFF, 1'b1, '{16'd0,   11'd1024, 1'b0, 1'b0}},
            '{oip_pkg::ACT_TAKE_ID,    16'd0,    1'b1, '{16'd1,   11'd1023, 1'b0, 1'b1}},
            '{oip_pkg::ACT_TAKE_ID,    16'd0,    1'b1, '{16'd1,   11'd1023, 1'b0, 1'b0}},
            '{oip_pkg::ACT_GIVE_BACK,  16'd0,    1'b1, '{16'd1,   11'd1024, 1'b0, 1'b1}},
            '{oip_pkg::ACT_TAKE_ID,    16'd1023, 1'b0, '0},
            '{oip_pkg::ACT_TAKE_ID,    16'd500,  1'b0, '0},
            '{oip_pkg::ACT_TAKE_FRONT, 16'd3,    1'b0, '0},
            '{oip_pkg::ACT_TAKE_FRONT, 16'd1019, 1'b0, '0},
            '{oip_pkg::ACT_GIVE_BACK,  16'd1023, 1'b0, '0},
            '{oip_pkg::ACT_INIT,       16'hFFFF, 1'b1, '{16'd0,   11'd1024, 1'b0, 1'b1}}
        };
        wait (aresetn);
        foreach (plan[i]) send_item(plan[i].act, plan[i].operand, plan[i].fixed,
                                    plan[i].status);
        drain();

        // Tiny range: empty the pool, then refill from empty
        set_range(16'd100, 16'd102);
        plan = '{
            '{oip_pkg::ACT_GIVE_BACK,  16'd101,  1'b0, '0},
            '{oip_pkg::ACT_INIT,       16'd0,    1'b1, '{16'd100, 11'd3,    1'b0, 1'b1}},
            '{oip_pkg::ACT_TAKE_FRONT, 16'd2,    1'b1, '{16'd102, 11'd1,    1'b0, 1'b1}},
            '{oip_pkg::ACT_TAKE_FRONT, 16'd1,    1'b1, '{16'd102, 11'd1,    1'b0, 1'b0}},
            '{oip_pkg::ACT_TAKE_ID,    16'd102,  1'b1, '{16'd0,   11'd0,    1'b1, 1'b1}},
            '{oip_pkg::ACT_TAKE_ID,    16'd102,  1'b1, '{16'd0,   11'd0,    1'b1, 1'b0}},
            '{oip_pkg::ACT_GIVE_BACK,  16'd103,  1'b1, '{16'd0,   11'd0,    1'b1, 1'b0}},
            '{oip_pkg::ACT_GIVE_BACK,  16'd101,  1'b1, '{16'd101, 11'd1,    1'b0, 1'b1}},
            '{oip_pkg::ACT_GIVE_BACK,  16'd100,  1'b1, '{16'd101, 11'd2,    1'b0, 1'b1}}
        };
        foreach (plan[i]) send_item(plan[i].act, plan[i].operand, plan[i].fixed,
                                    plan[i].status);
        drain();

        // Inverted range, then a range change without init
        set_range(16'hFFFF, 16'd0);
        send_item(oip_pkg::ACT_INIT, 16'd0, 1'b1, '{16'hFFFF, 11'd1, 1'b0, 1'b1});
        send_item(oip_pkg::ACT_TAKE_ID, 16'hFFFF, 1'b1, '{16'd0, 11'd0, 1'b1, 1'b1});
        send_item(oip_pkg::ACT_GIVE_BACK, 16'hFFFF, 1'b1, '{16'hFFFF, 11'd1, 1'b0, 1'b1});
        drain();
        set_range(16'hFFF0, 16'hFFFF);
        send_item(oip_pkg::ACT_GIVE_BACK, 16'hFFF5, 1'b0, '0);
        drain();

        // Random phases over several ranges, including a full-width one
        for (int ph = 0; ph < 5; ph++) begin
            stall_mode <= ph % 3;
            case (ph)
                0: set_range(16'd0, 16'hFFFF);
                1: set_range(16'd20, 16'd27);
                2: set_range(16'hFC00, 16'hFFFF);
                3: set_range(16'($urandom), 16'($urandom));
                default: set_range(16'd7, 16'd70);
            endcase
            send_item(oip_pkg::ACT_INIT, 16'($urandom), 1'b0, '0);
            if (ph == 0) hold_req = 1'b1;
            for (int i = 0; i < 100; i++) random_item();
            drain();
        end

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
